@@ rtl/core/icmprc_pkg.sv @@
// Shared types and constants of the ICMP reply classifier.
package icmprc_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_CLAMP,
		ST_SQUARE,
		ST_UPDATE,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic capture;
		logic finish;
		logic eval;
		logic mul;
		logic clamp;
		logic square;
		logic update;
	} cmd_t;

	localparam logic [2:0] STAT_SHORT      = 3'd0;
	localparam logic [2:0] STAT_REPLY      = 3'd1;
	localparam logic [2:0] STAT_DUPLICATE  = 3'd2;
	localparam logic [2:0] STAT_WRONG_ID   = 3'd3;
	localparam logic [2:0] STAT_TTL_MATCH  = 3'd4;
	localparam logic [2:0] STAT_TTL_SHORT  = 3'd5;
	localparam logic [2:0] STAT_TTL_OTHER  = 3'd6;
	localparam logic [2:0] STAT_OTHER_TYPE = 3'd7;

	localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;
	localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
	localparam logic [7:0] ICMP_TIME_EXCEED  = 8'd11;

	localparam logic signed [21:0] USEC_PER_SEC = 22'sd1000000;

endpackage

@@ rtl/core/icmprc_ctrl.sv @@
// Sequencer for the classifier: byte intake, then the end-of-packet steps.
module icmprc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last,
	input  logic               out_stall,
	output logic               in_stall,
	output logic               out_valid,
	output icmprc_pkg::cmd_t   cmd
);
	import icmprc_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.capture = in_valid;
				cmd.finish = in_valid && last;
				if (in_valid && last) state_n = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_n = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_n = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_n = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_n = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_n = ST_SEND;
			end
			ST_SEND: begin
				out_valid = 1'b1;
				if (!out_stall) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule

@@ rtl/core/icmprc_dp.sv @@
// Datapath: header capture, classification, RTT arithmetic and statistics.
module icmprc_dp #(
	parameter int MAX_PACKET_BYTES = 65535
) (
	input  logic               clk,
	input  logic               arst_n,
	input  icmprc_pkg::cmd_t   cmd,
	input  logic               cfg_write_en,
	input  logic [15:0]        cfg_write_data,
	input  logic [7:0]         data_byte,
	input  logic [31:0]        recv_sec,
	input  logic [19:0]        recv_usec,
	input  logic [31:0]        sent_count,
	output logic [2:0]         status,
	output logic [15:0]        seq_number,
	output logic [7:0]         hop_ttl,
	output logic [31:0]        rtt_us,
	output logic [15:0]        icmp_bytes,
	output logic [31:0]        received_total,
	output logic [31:0]        responded_total,
	output logic [31:0]        rtt_min_us,
	output logic [31:0]        rtt_max_us,
	output logic [47:0]        rtt_sum_us,
	output logic [63:0]        rtt_square_sum
);
	import icmprc_pkg::*;

	localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

	logic [15:0] echo_ident_q;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [5:0] ohl_q, ohl_n, ihl_q, ihl_n;
	logic [7:0] ttl_q, ttl_n, type_q, type_n;
	logic [15:0] id_q, id_n, seq_q, seq_n;
	logic [31:0] ss_q, ss_n, su_q, su_n;
	logic [39:0] inner_q, inner_n;
	logic [15:0] len_q;
	logic [31:0] rs_q, sent_q;
	logic [19:0] ru_q;

	logic live, pos0, in_hdr, in_inner;
	logic [15:0] pos16, off, j;

	assign live  = pos_q < POS_MAX;
	assign pos0  = pos_q == '0;
	assign pos16 = 16'(pos_q);
	assign pos_n = live ? pos_q + POS_W'(1) : pos_q;

	always_comb begin
		ohl_n = pos0 ? {data_byte[3:0], 2'b00} : ohl_q;
		ttl_n = pos0 ? 8'd0 : ttl_q;
		type_n = pos0 ? 8'd0 : type_q;
		id_n = pos0 ? 16'd0 : id_q;
		seq_n = pos0 ? 16'd0 : seq_q;
		ss_n = pos0 ? 32'd0 : ss_q;
		su_n = pos0 ? 32'd0 : su_q;
		ihl_n = pos0 ? 6'd0 : ihl_q;
		inner_n = pos0 ? 40'd0 : inner_q;
		if (pos16 == 16'd8) ttl_n = data_byte;
		in_hdr = pos16 >= 16'(ohl_n);
		off = pos16 - 16'(ohl_n);
		if (in_hdr) begin
			unique case (off)
				16'd0:  type_n = data_byte;
				16'd4:  id_n[15:8] = data_byte;
				16'd5:  id_n[7:0] = data_byte;
				16'd6:  seq_n[15:8] = data_byte;
				16'd7:  seq_n[7:0] = data_byte;
				16'd8:  ss_n[31:24] = data_byte;
				16'd9:  ss_n[23:16] = data_byte;
				16'd10: ss_n[15:8] = data_byte;
				16'd11: ss_n[7:0] = data_byte;
				16'd12: su_n[31:24] = data_byte;
				16'd13: su_n[23:16] = data_byte;
				16'd14: su_n[15:8] = data_byte;
				16'd15: su_n[7:0] = data_byte;
				default: ;
			endcase
			if (off == 16'd8) ihl_n = {data_byte[3:0], 2'b00};
		end
		// The inner header length takes effect on its own byte.
		in_inner = in_hdr && off >= 16'd8 && (off - 16'd8) >= 16'(ihl_n);
		j = off - 16'd8 - 16'(ihl_n);
		if (in_inner) begin
			unique case (j)
				16'd0: inner_n[39:32] = data_byte;
				16'd4: inner_n[31:24] = data_byte;
				16'd5: inner_n[23:16] = data_byte;
				16'd6: inner_n[15:8] = data_byte;
				16'd7: inner_n[7:0] = data_byte;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			echo_ident_q <= '0;
		end else begin
			if (cfg_write_en) echo_ident_q <= cfg_write_data;
			if (cmd.finish) begin
				pos_q <= '0;
			end else if (cmd.capture) begin
				pos_q <= pos_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture && live) begin
			ohl_q <= ohl_n;
			ttl_q <= ttl_n;
			type_q <= type_n;
			id_q <= id_n;
			seq_q <= seq_n;
			ss_q <= ss_n;
			su_q <= su_n;
			ihl_q <= ihl_n;
			inner_q <= inner_n;
		end
		if (cmd.finish) begin
			len_q <= 16'(pos_n);
			rs_q <= recv_sec;
			ru_q <= recv_usec;
			sent_q <= sent_count;
		end
	end

	// Classification and first RTT step.
	logic short_c, match_c, stamp_c, te_c;
	logic [15:0] icmp_len_c, seq_c;
	logic [2:0] status_c;
	logic signed [33:0] dsec_c, dus_c;

	always_comb begin
		short_c = {1'b0, len_q} < 17'(ohl_q) + 17'd8;
		icmp_len_c = len_q - 16'(ohl_q);
		match_c = 1'b0;
		stamp_c = icmp_len_c >= 16'd16;
		te_c = 1'b0;
		seq_c = seq_q;
		if (short_c) begin
			status_c = STAT_SHORT;
			icmp_len_c = 16'd0;
			seq_c = 16'd0;
		end else if (type_q == ICMP_ECHO_REPLY) begin
			if (id_q != echo_ident_q) begin
				status_c = STAT_WRONG_ID;
			end else begin
				match_c = 1'b1;
				if (sent_q != 32'd0 && 33'(seq_q) + 33'd1 < 33'(sent_q))
					status_c = STAT_DUPLICATE;
				else
					status_c = STAT_REPLY;
			end
		end else if (type_q == ICMP_TIME_EXCEED) begin
			te_c = 1'b1;
			if (icmp_len_c < 16'd20 || icmp_len_c < 16'(ihl_q) + 16'd8) begin
				status_c = STAT_TTL_SHORT;
			end else if (inner_q[39:32] == ICMP_ECHO_REQUEST &&
			             inner_q[31:16] == echo_ident_q) begin
				status_c = STAT_TTL_MATCH;
				seq_c = inner_q[15:0];
			end else begin
				status_c = STAT_TTL_OTHER;
			end
		end else begin
			status_c = STAT_OTHER_TYPE;
		end
		dsec_c = $signed({2'b00, rs_q}) - $signed({2'b00, ss_q});
		dus_c = $signed({14'd0, ru_q}) - $signed({2'b00, su_q});
		// One-second borrow, also when the stamp is out of range.
		if (dus_c < 0) begin
			dsec_c = dsec_c - 34'sd1;
			dus_c = dus_c + 34'sd1000000;
		end
	end

	logic do_stats_q, match_q, te_q;
	logic signed [33:0] dsec_s1, dus_s1, dus_s2;
	logic signed [55:0] prod_s2;
	logic [31:0] rtt_s3;
	logic [63:0] sq_s4;
	logic signed [55:0] t_c;

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			status <= status_c;
			seq_number <= seq_c;
			icmp_bytes <= icmp_len_c;
			hop_ttl <= ttl_q;
			match_q <= match_c;
			te_q <= te_c;
			do_stats_q <= match_c && stamp_c;
			dsec_s1 <= dsec_c;
			dus_s1 <= dus_c;
		end
		if (cmd.mul) begin
			prod_s2 <= 56'(dsec_s1) * 56'(USEC_PER_SEC);
			dus_s2 <= dus_s1;
		end
		if (cmd.clamp) begin
			if (t_c < 0)
				rtt_s3 <= 32'd0;
			else if (t_c > 56'sh0_0000_FFFF_FFFF)
				rtt_s3 <= 32'hFFFF_FFFF;
			else
				rtt_s3 <= t_c[31:0];
		end
		if (cmd.square) begin
			sq_s4 <= 64'(rtt_s3) * 64'(rtt_s3);
			rtt_us <= do_stats_q ? rtt_s3 : 32'd0;
		end
	end

	assign t_c = prod_s2 + 56'(dus_s2);

	logic [48:0] sum_c;
	logic [64:0] sqs_c;
	assign sum_c = {1'b0, rtt_sum_us} + 49'(rtt_s3);
	assign sqs_c = {1'b0, rtt_square_sum} + {1'b0, sq_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			received_total <= '0;
			responded_total <= '0;
			rtt_min_us <= '1;
			rtt_max_us <= '0;
			rtt_sum_us <= '0;
			rtt_square_sum <= '0;
		end else if (cmd.update) begin
			if (match_q) received_total <= received_total + 32'd1;
			if (match_q || te_q) responded_total <= responded_total + 32'd1;
			if (do_stats_q) begin
				rtt_sum_us <= sum_c[48] ? '1 : sum_c[47:0];
				rtt_square_sum <= sqs_c[64] ? '1 : sqs_c[63:0];
				if (rtt_s3 < rtt_min_us) rtt_min_us <= rtt_s3;
				if (rtt_s3 > rtt_max_us) rtt_max_us <= rtt_s3;
			end
		end
	end

endmodule

@@ rtl/core/icmp_reply_classifier_rtt_stats.sv @@
// Top level of the ICMP reply classifier with round-trip statistics.
// Packet bytes enter on the input channel (in_valid, in_stall), one word per
// cycle, with last marking the final byte; recv_sec, recv_usec and
// sent_count are sampled with that last word. Every packet yields one result
// word on the output channel (out_valid, out_stall) carrying the class, the
// sequence, TTL, RTT and the statistics after that packet.
// Non-final bytes are taken at one per cycle. After the last byte the block
// runs five steps (classify, seconds-to-microseconds multiply, clamp, square,
// statistics update) and then holds the result with out_valid high until it is
// taken; in_stall is high from the last byte until the result is taken.
// While out_stall is high the result word holds and no input is taken.
// Reset clears the byte counter, the counters and sums, sets the minimum RTT
// to all ones and clears the expected identifier. The identifier register
// may be written at any idle time through cfg_write_en and cfg_write_data.
module icmp_reply_classifier_rtt_stats #(
	parameter int MAX_PACKET_BYTES = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [15:0] cfg_write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	input  logic [31:0] recv_sec,
	input  logic [19:0] recv_usec,
	input  logic [31:0] sent_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] seq_number,
	output logic [7:0]  hop_ttl,
	output logic [31:0] rtt_us,
	output logic [15:0] icmp_bytes,
	output logic [31:0] received_total,
	output logic [31:0] responded_total,
	output logic [31:0] rtt_min_us,
	output logic [31:0] rtt_max_us,
	output logic [47:0] rtt_sum_us,
	output logic [63:0] rtt_square_sum
);
	import icmprc_pkg::*;

	cmd_t cmd;

	icmprc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	icmprc_dp #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_write_en    (cfg_write_en),
		.cfg_write_data  (cfg_write_data),
		.data_byte       (data_byte),
		.recv_sec        (recv_sec),
		.recv_usec       (recv_usec),
		.sent_count      (sent_count),
		.status          (status),
		.seq_number      (seq_number),
		.hop_ttl         (hop_ttl),
		.rtt_us          (rtt_us),
		.icmp_bytes      (icmp_bytes),
		.received_total  (received_total),
		.responded_total (responded_total),
		.rtt_min_us      (rtt_min_us),
		.rtt_max_us      (rtt_max_us),
		.rtt_sum_us      (rtt_sum_us),
		.rtt_square_sum  (rtt_square_sum)
	);

	a_no_intake_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

	a_last_blocks_intake: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last) |=> in_stall)
		else $error("input not blocked after the last byte");

	a_rtt_only_for_replies: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STAT_REPLY && status != STAT_DUPLICATE) |-> rtt_us == 32'd0)
		else $error("RTT reported for a packet that is not an echo reply");

	a_short_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_SHORT) |-> (icmp_bytes == 16'd0 && seq_number == 16'd0))
		else $error("short packet reports length or sequence");

endmodule
